[design/stk_pkg.sv]
// Shared types and constants for the source tokenizer stream.
package stk_pkg;

    localparam int LEN_BITS  = 16;
    localparam int POS_BITS  = 32;
    localparam int RES_SLOTS = 3;

    typedef logic [LEN_BITS-1:0] len_t;
    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [1:0]          res_cnt_t;

    typedef enum logic [2:0] {
        KIND_END      = 3'd0,
        KIND_NEWLINE  = 3'd1,
        KIND_COMMENT  = 3'd2,
        KIND_DONTCARE = 3'd3,
        KIND_LITERAL  = 3'd4,
        KIND_SYMBOL   = 3'd5,
        KIND_INTEGER  = 3'd6,
        KIND_INVALID  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SYMBOL,
        MODE_LITERAL,
        MODE_COMMENT,
        MODE_SLASH,
        MODE_RUN,
        MODE_RUNSLASH
    } mode_t;

    typedef struct packed {
        kind_t kind;
        pos_t  start_pos;
        len_t  length;
        logic  dir_end;
        logic  last;
    } result_t;

    typedef struct packed {
        mode_t mode;
        logic  dmode;
        kind_t open_kind;
        len_t  open_len;
        pos_t  open_start;
        logic  hash_pend;
        pos_t  position;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:       MODE_IDLE,
        dmode:      1'b0,
        open_kind:  KIND_END,
        open_len:   '0,
        open_start: '0,
        hash_pend:  1'b0,
        position:   '0
    };

endpackage

[design/source_tokenizer_stream.sv]
// Top level of the streaming source tokenizer: input register, scanner state, result buffer.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | s_valid s_ready s_ch s_is_final               | in
//  result  | m_valid m_ready m_kind m_start_pos m_length   | out
//          | m_directive_end m_last_of_run                 |
//
// A byte is registered, scanned combinationally and its tokens (0 to 3) land in the
// result buffer; one byte per cycle is sustained while each byte yields at most one token and m_ready is high.
// A byte yielding more than one token holds the scanner while the buffer drains.
// An input byte passes the input register, then the result buffer, before its first result is offered.
// Synchronous active-low reset clears the scanner; no clearing pass.
// A stalled result side backs up into s_ready once the buffer and input register fill.
module source_tokenizer_stream import stk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_is_final,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_start_pos,
    output logic [15:0] m_length,
    output logic        m_directive_end,
    output logic        m_last_of_run
);

    logic                    in_valid_reg;
    logic [7:0]              ch_reg;
    logic                    fin_reg;
    scan_state_t             state_reg;
    scan_state_t             state_next;
    result_t [RES_SLOTS-1:0] step_res;
    res_cnt_t                step_cnt;
    logic                    can_load;
    logic                    fire;
    logic                    load;

    assign fire    = in_valid_reg && ((step_cnt == '0) || can_load);
    assign load    = fire && (step_cnt != '0);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_ch;
            fin_reg <= s_is_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    stk_step u_step (
        .state_i  (state_reg),
        .ch       (ch_reg),
        .is_final (fin_reg),
        .state_o  (state_next),
        .res      (step_res),
        .res_cnt  (step_cnt)
    );

    stk_outbuf u_outbuf (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .load_res        (step_res),
        .load_cnt        (step_cnt),
        .can_load        (can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_start_pos     (m_start_pos),
        .m_length        (m_length),
        .m_directive_end (m_directive_end),
        .m_last_of_run   (m_last_of_run)
    );

    // end token always closes the run of its byte
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_END)) |-> m_last_of_run)
        else $error("end token without last_of_run");

    // only a newline can close directive mode
    a_dend_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_directive_end) |-> (m_kind == KIND_NEWLINE))
        else $error("directive_end on non-newline token");

    // a final byte restarts offsets at zero
    a_final_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && fin_reg) |=> ((state_reg.position == '0) && (state_reg.mode == MODE_IDLE)))
        else $error("scanner not restarted after final byte");

    // a final byte always produces at least the end token
    a_final_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && fin_reg) |-> (step_cnt != '0))
        else $error("final byte without end token");

endmodule

[design/stk_step.sv]
// Combinational scan step: one byte against the scanner state, up to three tokens out.
module stk_step import stk_pkg::*; (
    input  scan_state_t                 state_i,
    input  logic [7:0]                  ch,
    input  logic                        is_final,
    output scan_state_t                 state_o,
    output result_t [RES_SLOTS-1:0]     res,
    output res_cnt_t                    res_cnt
);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam len_t       LEN_TWO  = len_t'(2);

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic sym_first(input logic [7:0] c);
        return c[7] || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic sym_rest(input logic [7:0] c);
        return sym_first(c) || is_digit(c);
    endfunction

    function automatic logic run_byte(input logic [7:0] c);
        return is_digit(c) || (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h2C, 8'h3B, 8'h25,
            8'h3E, 8'h3C, 8'h3D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D});
    endfunction

    function automatic len_t sat_inc(input len_t v);
        return (v == '1) ? v : v + len_t'(1);
    endfunction

    function automatic result_t mk(input kind_t k, input pos_t s, input len_t l, input logic d);
        result_t r;
        r.kind      = k;
        r.start_pos = s;
        r.length    = l;
        r.dir_end   = d;
        r.last      = 1'b0;
        return r;
    endfunction

    scan_state_t s;
    result_t     cand [4];
    logic [3:0]  cv;
    logic        disp;
    logic        run;
    res_cnt_t    n;
    pos_t        pos;

    always_comb begin
        s    = state_i;
        pos  = state_i.position;
        cv   = '0;
        disp = 1'b0;
        run  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            cand[i] = '0;
        end

        // continue or close the open token
        case (s.mode)
            MODE_SYMBOL: begin
                if (sym_rest(ch) || (s.dmode && (ch == CH_DOT || ch == CH_SLASH))) begin
                    s.open_len = sat_inc(s.open_len);
                end else begin
                    cv[0]   = 1'b1;
                    cand[0] = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
                    s.mode  = MODE_IDLE;
                    disp    = 1'b1;
                end
            end
            MODE_LITERAL: begin
                if (ch == CH_QUOTE) begin
                    s.open_len = sat_inc(s.open_len);
                    cv[0]      = 1'b1;
                    cand[0]    = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
                    s.mode     = MODE_IDLE;
                end else if (ch == CH_NL) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
                    s.mode  = MODE_IDLE;
                    disp    = 1'b1;
                end else begin
                    s.open_len = sat_inc(s.open_len);
                end
            end
            MODE_COMMENT: begin
                if (ch == CH_NL) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
                    s.mode  = MODE_IDLE;
                    disp    = 1'b1;
                end else begin
                    s.open_len = sat_inc(s.open_len);
                end
            end
            MODE_SLASH: begin
                if (ch == CH_SLASH) begin
                    s.open_len  = sat_inc(s.open_len);
                    s.open_kind = KIND_COMMENT;
                    s.mode      = MODE_COMMENT;
                end else begin
                    s.mode = MODE_RUN;
                    run    = 1'b1;
                end
            end
            MODE_RUN: begin
                run = 1'b1;
            end
            MODE_RUNSLASH: begin
                if (ch == CH_SLASH) begin
                    // run ends before a line comment
                    cv[0]        = 1'b1;
                    cand[0]      = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
                    s.open_start = pos - pos_t'(1);
                    s.open_len   = LEN_TWO;
                    s.open_kind  = KIND_COMMENT;
                    s.mode       = MODE_COMMENT;
                end else begin
                    s.open_len = sat_inc(s.open_len);
                    s.mode     = MODE_RUN;
                    run        = 1'b1;
                end
            end
            default: begin
                s.mode = MODE_IDLE;
                disp   = 1'b1;
            end
        endcase

        if (run) begin
            if (ch == CH_SLASH) begin
                s.mode = MODE_RUNSLASH;
            end else if (run_byte(ch)) begin
                s.open_len = sat_inc(s.open_len);
            end else begin
                cv[0]   = 1'b1;
                cand[0] = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
                s.mode  = MODE_IDLE;
                disp    = 1'b1;
            end
        end

        // start a new token
        if (disp && !is_blank(ch)) begin
            if (ch == CH_HASH) begin
                if (!s.hash_pend) begin
                    s.open_start = pos;
                    s.open_len   = '0;
                end
                s.open_len  = sat_inc(s.open_len);
                s.hash_pend = 1'b1;
                s.dmode     = 1'b1;
            end else begin
                if (!s.hash_pend) begin
                    s.open_start = pos;
                    s.open_len   = '0;
                end
                s.hash_pend = 1'b0;
                s.open_len  = sat_inc(s.open_len);
                if (ch == CH_NL) begin
                    cv[1]   = 1'b1;
                    cand[1] = mk(KIND_NEWLINE, s.open_start, s.open_len, s.dmode);
                    s.dmode = 1'b0;
                end else if (ch == CH_SLASH) begin
                    s.open_kind = KIND_DONTCARE;
                    s.mode      = MODE_SLASH;
                end else if (s.dmode && (ch == CH_GT || ch == CH_QUOTE)) begin
                    cv[1]   = 1'b1;
                    cand[1] = mk(KIND_DONTCARE, s.open_start, s.open_len, 1'b0);
                end else if (ch == CH_QUOTE) begin
                    s.open_kind = KIND_LITERAL;
                    s.mode      = MODE_LITERAL;
                end else if (sym_first(ch)) begin
                    s.open_kind = KIND_SYMBOL;
                    s.mode      = MODE_SYMBOL;
                end else if (run_byte(ch)) begin
                    s.open_kind = is_digit(ch) ? KIND_INTEGER : KIND_DONTCARE;
                    s.mode      = MODE_RUN;
                end else begin
                    cv[1]   = 1'b1;
                    cand[1] = mk(KIND_INVALID, s.open_start, s.open_len, 1'b0);
                end
            end
        end

        s.position = pos + pos_t'(1);

        // end of content: flush, end token, back to reset
        if (is_final) begin
            if (s.mode == MODE_RUNSLASH) begin
                s.open_len = sat_inc(s.open_len);
            end
            if (s.mode != MODE_IDLE) begin
                cv[2]   = 1'b1;
                cand[2] = mk(s.open_kind, s.open_start, s.open_len, 1'b0);
            end
            cv[3] = 1'b1;
            if (s.hash_pend) begin
                cand[3] = mk(KIND_END, s.open_start, s.open_len, 1'b0);
            end else begin
                cand[3] = mk(KIND_END, s.position, '0, 1'b0);
            end
            s = SCAN_RESET;
        end

        // pack in order
        n   = '0;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i] && (n != 2'd3)) begin
                res[n] = cand[i];
                n      = n + 2'd1;
            end
        end
        if (n != '0) begin
            res[n - 2'd1].last = 1'b1;
        end

        state_o = s;
        res_cnt = n;
    end

endmodule

[design/stk_outbuf.sv]
// Three-slot result buffer that drains one token per transaction.
module stk_outbuf import stk_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  result_t [RES_SLOTS-1:0] load_res,
    input  res_cnt_t                load_cnt,
    output logic                    can_load,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_kind,
    output logic [31:0]             m_start_pos,
    output logic [15:0]             m_length,
    output logic                    m_directive_end,
    output logic                    m_last_of_run
);

    result_t [RES_SLOTS-1:0] slots_reg;
    res_cnt_t                cnt_reg;
    logic                    take;

    assign take     = (cnt_reg != '0) && m_ready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == res_cnt_t'(1)) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= load_cnt;
        end else if (take) begin
            cnt_reg <= cnt_reg - res_cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slots_reg <= load_res;
        end else if (take) begin
            slots_reg[0] <= slots_reg[1];
            slots_reg[1] <= slots_reg[2];
        end
    end

    assign m_valid         = (cnt_reg != '0);
    assign m_kind          = slots_reg[0].kind;
    assign m_start_pos     = slots_reg[0].start_pos;
    assign m_length        = slots_reg[0].length;
    assign m_directive_end = slots_reg[0].dir_end;
    assign m_last_of_run   = slots_reg[0].last;

endmodule
